FILE: rtl/rau_pkg.sv
package rau_pkg;

  // operation kinds
  localparam logic [2:0] KIND_ADD  = 3'd0;
  localparam logic [2:0] KIND_SUB  = 3'd1;
  localparam logic [2:0] KIND_MUL  = 3'd2;
  localparam logic [2:0] KIND_DIV  = 3'd3;
  localparam logic [2:0] KIND_NORM = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  // intermediate magnitude width
  localparam int unsigned WIDE = 64;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture operands and check them
    logic mul_a;     // first product step
    logic mul_b;     // second product step
    logic combine;   // form num/den magnitudes
    logic gcd_step;  // one binary gcd step
    logic div_start; // start the two quotient divisions
    logic div_step;  // one restoring division bit
    logic finish;    // range check and result register
  } rau_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic early;     // operand error, result already known
    logic gcd_done;
    logic div_done;
  } rau_stat_t;

endpackage

FILE: rtl/rau_ctrl.sv
module rau_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               out_free,
  input  rau_pkg::rau_stat_t stat,
  output rau_pkg::rau_cmd_t  cmd,
  output logic               busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULA = 3'd1;
  localparam logic [2:0] S_MULB = 3'd2;
  localparam logic [2:0] S_COMB = 3'd3;
  localparam logic [2:0] S_GCD  = 3'd4;
  localparam logic [2:0] S_DIVS = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_r, state_nxt;

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_MULA;
        end
      end
      S_MULA: begin
        if (stat.early) begin
          state_nxt = S_FIN;
        end else begin
          cmd.mul_a = 1'b1;
          state_nxt = S_MULB;
        end
      end
      S_MULB: begin
        cmd.mul_b = 1'b1;
        state_nxt = S_COMB;
      end
      S_COMB: begin
        cmd.combine = 1'b1;
        state_nxt = S_GCD;
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          state_nxt = S_DIVS;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

FILE: rtl/rau_dp.sv
module rau_dp #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  rau_pkg::rau_cmd_t  cmd,
  input  logic [2:0]         kind,
  input  logic [31:0]        a_num,
  input  logic [31:0]        a_den,
  input  logic [31:0]        b_num,
  input  logic [30:0]        b_den,
  output rau_pkg::rau_stat_t stat,
  output logic [31:0]        res_num,
  output logic [30:0]        res_den,
  output logic [1:0]         res_status
);

  localparam int W = rau_pkg::WIDE;
  localparam int CW = $clog2(W + 1);
  localparam logic [W-1:0] LIM = {{(W-1){1'b0}}, 1'b1} << (VALUE_WIDTH - 1);

  // operand registers (33 bits; b_den zero-extended, the others sign-extended)
  logic [2:0]         kind_r;
  logic signed [32:0] an_r, ad_r, bn_r, bd_r;
  logic               early_r;
  logic [1:0]         est_r;
  // product registers
  logic signed [65:0] p0_r, p1_r, p2_r;
  // gcd state
  logic               neg_r;
  logic [W-1:0]       mag_r, den_r, gx_r, gy_r;
  logic [CW-1:0]      gsh_r;
  // division state
  logic [W-1:0]       qn_r, qd_r, rn_r, rd_r, dv_r;
  logic [CW-1:0]      cnt_r;
  logic [31:0]        res_num_r;
  logic [30:0]        res_den_r;
  logic [1:0]         res_st_r;

  logic signed [65:0] num_w, den_w;
  logic [W-1:0]       gdiff;
  logic [W:0]         trn, trd;

  // operand checks
  logic bad_w, div0_w;
  always_comb begin
    bad_w = 1'b0;
    div0_w = 1'b0;
    if (kind > rau_pkg::KIND_NORM) begin
      bad_w = 1'b1;
    end else if (kind == rau_pkg::KIND_NORM) begin
      bad_w = (a_den == 32'd0);
    end else begin
      bad_w = a_den[31] || (a_den == 32'd0) || (b_den == 31'd0);
      div0_w = !bad_w && (kind == rau_pkg::KIND_DIV) && (b_num == 32'd0);
    end
  end

  // capture and products
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      an_r <= {a_num[31], a_num};
      ad_r <= {a_den[31], a_den};
      bn_r <= {b_num[31], b_num};
      bd_r <= {2'b00, b_den};
      early_r <= bad_w || div0_w;
      est_r <= bad_w ? rau_pkg::ST_BAD : rau_pkg::ST_DIV0;
    end
    if (cmd.mul_a) begin
      // p0: an*bd, p1: bn*ad (or an*bn for multiply)
      p0_r <= an_r * bd_r;
      p1_r <= (kind_r == rau_pkg::KIND_MUL) ? an_r * bn_r : bn_r * ad_r;
    end
    if (cmd.mul_b) begin
      // denominator product; divide uses ad*|bn|
      if (kind_r == rau_pkg::KIND_DIV) begin
        p2_r <= ad_r * (bn_r[32] ? -bn_r : bn_r);
        if (bn_r[32]) p0_r <= -p0_r;
      end else begin
        p2_r <= ad_r * bd_r;
      end
    end
  end

  // combine into signed num and positive den
  always_comb begin
    case (kind_r)
      rau_pkg::KIND_ADD: num_w = p0_r + p1_r;
      rau_pkg::KIND_SUB: num_w = p0_r - p1_r;
      rau_pkg::KIND_MUL: num_w = p1_r;
      rau_pkg::KIND_DIV: num_w = p0_r;
      default: num_w = ad_r[32] ? -{{33{an_r[32]}}, an_r} : {{33{an_r[32]}}, an_r};
    endcase
    if (kind_r == rau_pkg::KIND_NORM) begin
      den_w = ad_r[32] ? -{{33{ad_r[32]}}, ad_r} : {{33{ad_r[32]}}, ad_r};
    end else begin
      den_w = p2_r;
    end
  end

  // binary gcd: strip common twos, then subtract-and-shift
  assign gdiff = (gx_r > gy_r) ? gx_r - gy_r : gy_r - gx_r;
  assign stat.gcd_done = (gx_r == 64'd0) || (gy_r == 64'd0) ||
                         ((gx_r[0] || gy_r[0]) && (gx_r == gy_r));
  always_ff @(posedge clk) begin
    if (cmd.combine) begin
      neg_r <= num_w[65];
      mag_r <= W'(num_w[65] ? -num_w : num_w);
      den_r <= W'(den_w);
      gx_r <= W'(num_w[65] ? -num_w : num_w);
      gy_r <= W'(den_w);
      gsh_r <= '0;
    end else if (cmd.gcd_step) begin
      if (!gx_r[0] && !gy_r[0]) begin
        gx_r <= gx_r >> 1;
        gy_r <= gy_r >> 1;
        gsh_r <= gsh_r + 1'b1;
      end else if (!gx_r[0]) begin
        gx_r <= gx_r >> 1;
      end else if (!gy_r[0]) begin
        gy_r <= gy_r >> 1;
      end else if (gx_r > gy_r) begin
        gx_r <= gdiff >> 1;
      end else begin
        gy_r <= gdiff >> 1;
      end
    end
  end

  // restoring division of mag and den by gcd, one bit per cycle for both
  assign trn = {rn_r, qn_r[W-1]} - {1'b0, dv_r};
  assign trd = {rd_r, qd_r[W-1]} - {1'b0, dv_r};
  assign stat.div_done = (cnt_r == '0);
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      // gcd(0,d)=d; result 0/1 falls out
      dv_r <= ((gx_r == 64'd0) ? gy_r : gx_r) << gsh_r;
      qn_r <= mag_r;
      qd_r <= den_r;
      rn_r <= '0;
      rd_r <= '0;
      cnt_r <= CW'(W);
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r - 1'b1;
      if (!trn[W]) begin
        rn_r <= trn[W-1:0];
        qn_r <= {qn_r[W-2:0], 1'b1};
      end else begin
        rn_r <= {rn_r[W-2:0], qn_r[W-1]};
        qn_r <= {qn_r[W-2:0], 1'b0};
      end
      if (!trd[W]) begin
        rd_r <= trd[W-1:0];
        qd_r <= {qd_r[W-2:0], 1'b1};
      end else begin
        rd_r <= {rd_r[W-2:0], qd_r[W-1]};
        qd_r <= {qd_r[W-2:0], 1'b0};
      end
    end
  end

  assign stat.early = early_r;

  // range check and result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (early_r) begin
        res_num_r <= '0;
        res_den_r <= '0;
        res_st_r <= est_r;
      end else if ((qd_r > LIM - 1'b1) || (!neg_r && qn_r > LIM - 1'b1) ||
                   (neg_r && qn_r > LIM)) begin
        res_num_r <= '0;
        res_den_r <= '0;
        res_st_r <= rau_pkg::ST_OVF;
      end else begin
        res_num_r <= neg_r ? -qn_r[31:0] : qn_r[31:0];
        res_den_r <= qd_r[30:0];
        res_st_r <= rau_pkg::ST_OK;
      end
    end
  end

  assign res_num = res_num_r;
  assign res_den = res_den_r;
  assign res_status = res_st_r;

endmodule

FILE: rtl/rational_arithmetic_unit_top.sv
// Rational arithmetic unit.
// in_ channel: one transaction per operation, kind in tuser, operands in tdata.
// out_ channel: one transaction per operation, reduced num/den and status.
// Operation flow: a first and a second product step, a combine step, a binary gcd loop
// (one subtract-or-shift per cycle), a division start step, then a
// restoring divider that divides numerator and denominator by the gcd
// in parallel, then a finish step.
// Operand errors skip straight to the finish step.
// One operation is in flight at a time; in_tready is high while idle, so
// a new operation can start in the cycle after the previous one finishes.
// The result sits in an output register; the next operation can be
// accepted while it waits, and the finish cycle waits until the output
// register is free, so a stalled receiver holds its result unchanged.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// out_tvalid; no result is lost outside reset.
module rational_arithmetic_unit_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // a_num, a_den, b_num, b_den[30:0], zero pad
  input  logic [2:0]   in_tuser,  // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata, // res_num, res_den[30:0], zero pad
  output logic [1:0]   out_tuser  // status
);

  rau_pkg::rau_cmd_t  cmd;
  rau_pkg::rau_stat_t stat;
  logic busy, in_fire, out_free, ovalid_r;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic [1:0]  res_st;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign out_free = !ovalid_r || out_tready;

  rau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  rau_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .cmd(cmd), .kind(in_tuser),
    .a_num(in_tdata[31:0]), .a_den(in_tdata[63:32]),
    .b_num(in_tdata[95:64]), .b_den(in_tdata[126:96]),
    .stat(stat), .res_num(res_num), .res_den(res_den), .res_status(res_st)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.finish) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = {1'b0, res_den, res_num};
  assign out_tuser = res_st;

endmodule
